/* rtl/kc6_pkg.sv */
package kc6_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned COUNT_W      = 3;
  localparam int unsigned REPORT_SLOTS = 6;
  localparam int unsigned COUNT_MAX    = 7;
  localparam int unsigned MAX_KEYS_DEF = 6;
  localparam int unsigned OUT_TDATA_W  = 56;

  localparam logic [BYTE_W-1:0] MARK_BYTE  = 8'h00;
  localparam logic [BYTE_W-1:0] PRESS_LOW  = 8'h04;
  localparam logic [BYTE_W-1:0] PRESS_HIGH = 8'h65;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  typedef enum logic {
    OP_PRESS,
    OP_RELEASE
  } op_t;

  // count sits above the six slots, slot 0 in the lowest byte
  typedef struct packed {
    logic [COUNT_W-1:0]                    count;
    logic [REPORT_SLOTS-1:0][BYTE_W-1:0]   slot;
  } report_t;

  // engine <-> output stage handshake
  typedef struct packed {
    logic done;
  } eng_status_t;

  typedef struct packed {
    logic take;
  } eng_ctrl_t;

endpackage

/* rtl/kc6_engine.sv */
module kc6_engine import kc6_pkg::*; #(
  parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_byte,
  input  eng_ctrl_t         ctrl,
  output eng_status_t       status,
  output report_t           report
);

  localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);
  localparam int unsigned AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  state_t state, state_next;

  logic [BYTE_W-1:0] keys [MAX_KEYS];
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [BYTE_W-1:0] cur_byte;
  op_t               op, op_next;
  logic              pending;

  logic              in_accept;
  logic              pend_set, pend_clr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              total_inc, total_dec;
  logic [BYTE_W-1:0] key_rd;
  logic [CNT_W-1:0]  idx_m1;
  logic              key_match;

  assign in_accept = in_valid && in_ready;
  assign key_rd    = keys[idx[AW-1:0]];
  assign idx_m1    = idx - 1'b1;
  // the one comparator, reused on every scan step
  assign key_match = (key_rd == cur_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    op_next    = op;
    in_ready   = 1'b0;
    status     = '0;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx[AW-1:0];
    wr_data    = cur_byte;
    total_inc  = 1'b0;
    total_dec  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        idx_next = '0;
        if (in_valid) begin
          if (pending) begin
            pend_clr   = 1'b1;
            op_next    = OP_RELEASE;
            state_next = ST_SCAN;
          end else if (in_byte == MARK_BYTE) begin
            pend_set   = 1'b1;
            state_next = ST_FINISH;
          end else if (in_byte inside {[PRESS_LOW:PRESS_HIGH]}) begin
            op_next    = OP_PRESS;
            state_next = ST_SCAN;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        if (idx < total) begin
          if (key_match) begin
            if (op == OP_RELEASE) begin
              idx_next   = idx + 1'b1;
              state_next = ST_SHIFT;
            end else begin
              state_next = ST_FINISH;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end else begin
          // key not held
          if (op == OP_PRESS && total < CNT_W'(MAX_KEYS)) begin
            wr_en     = 1'b1;
            wr_addr   = total[AW-1:0];
            wr_data   = cur_byte;
            total_inc = 1'b1;
          end
          state_next = ST_FINISH;
        end
      end
      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_m1[AW-1:0];
        if (idx < total) begin
          wr_data  = key_rd;
          idx_next = idx + 1'b1;
        end else begin
          // clear the vacated top slot
          wr_data    = '0;
          total_dec  = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        status.done = 1'b1;
        if (ctrl.take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= '0;
      pending <= 1'b0;
      idx     <= '0;
      op      <= OP_PRESS;
      for (int i = 0; i < MAX_KEYS; i++) begin
        keys[i] <= '0;
      end
    end else begin
      idx <= idx_next;
      op  <= op_next;
      if (in_accept) begin
        cur_byte <= in_byte;
      end
      if (pend_set) begin
        pending <= 1'b1;
      end else if (pend_clr) begin
        pending <= 1'b0;
      end
      if (wr_en) begin
        keys[wr_addr] <= wr_data;
      end
      if (total_inc) begin
        total <= total + 1'b1;
      end else if (total_dec) begin
        total <= total - 1'b1;
      end
    end
  end

  for (genvar j = 0; j < REPORT_SLOTS; j++) begin : g_slot
    if (j < MAX_KEYS) begin : g_held
      assign report.slot[j] = (CNT_W'(j) < total) ? keys[j] : '0;
    end else begin : g_none
      assign report.slot[j] = '0;
    end
  end

  assign report.count = (32'(total) > 32'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : COUNT_W'(total);

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(MAX_KEYS))
    else $error("held key count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept && (pending || in_byte != MARK_BYTE) |=> state != ST_IDLE)
    else $error("engine idle right after taking an item");

  a_shift_release: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHIFT |-> op == OP_RELEASE && total != '0)
    else $error("shift without a held key to release");

  a_total_step: assert property (@(posedge clk) disable iff (rst)
    state != ST_FINISH |=> total == $past(total) || total == $past(total) + 1'b1
                           || total + 1'b1 == $past(total))
    else $error("held key count jumped");

  a_pending_idle: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |=> pending == $past(pending))
    else $error("release marker changed mid-item");

endmodule

/* rtl/keycode_stream_to_6key_report_core.sv */
// Keycode stream to six-key boot keyboard report.
//
// Input stream: one received byte per item on s_axis. 0x00 arms a release, and
// the next byte names the key to release; 0x04..0x65 presses a key; other bytes
// are ignored. Output stream: one report per input item on m_axis, six slots in
// order of press plus the held count.
//
// Each item is worked by a sequencer that walks the held-key list with a single
// comparator, one slot per cycle, then shifts later keys down one slot per cycle
// on a release. A marker or an ignored byte goes from idle straight to finish,
// a press or a release through scan (and shift) first; finish loads the report
// into the output register behind m_axis_tvalid. s_axis_tready is high only
// while the sequencer is idle, so a byte is not taken until the last is done.
//
// The report sits in an output register; the next byte is taken and worked
// while it waits. If m_axis_tready stays low, the sequencer holds its finished
// result and s_axis_tready stays low. Reset empties the list, drops a pending
// release marker and clears m_axis_tvalid.
module keycode_stream_to_6key_report_core import kc6_pkg::*; #(
  parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // rx_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // slot0..slot5, held_count, zero pad
);

  eng_ctrl_t   ctrl;
  eng_status_t status;
  report_t     report;
  report_t     out_report;
  logic        out_valid;

  kc6_engine #(
    .MAX_KEYS (MAX_KEYS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .ctrl     (ctrl),
    .status   (status),
    .report   (report)
  );

  assign ctrl.take = status.done && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.take) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      out_report <= report;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_TDATA_W - $bits(report_t))'(0), out_report};

endmodule

/* tb/sv/keycode_stream_to_6key_report_core_test.sv */
`timescale 1ns / 1ps

module keycode_stream_to_6key_report_core_test;
  import kc6_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // longest accept-to-report path is a press or a release, which scans the held-key list
  localparam int unsigned SETTLE       = MAX_KEYS_DEF + 10;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_PERIODIC
  } stall_mode_t;

  typedef struct {
    logic [BYTE_W-1:0] rx;
    bit                typed;
    bit                hold;
    report_t           want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // predictor state
  logic [BYTE_W-1:0] held_key [MAX_KEYS_DEF];
  int                held_num = 0;
  bit                release_armed = 1'b0;

  report_t     expected_reports [$];
  bit          failed = 1'b0;
  int unsigned cycles = 0;
  stall_mode_t rx_mode = RDY_ALWAYS;
  int unsigned mode_left = 0;

  keycode_stream_to_6key_report_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  function automatic report_t mk_report(input int cnt, input logic [7:0] s0, s1, s2, s3, s4,
                                        s5);
    report_t r;
    r.count   = COUNT_W'(cnt);
    r.slot[0] = s0;
    r.slot[1] = s1;
    r.slot[2] = s2;
    r.slot[3] = s3;
    r.slot[4] = s4;
    r.slot[5] = s5;
    return r;
  endfunction

  // updates the held-key list for one received byte, returns the report that follows
  function automatic report_t apply_rx_byte(input logic [BYTE_W-1:0] b);
    report_t r;
    int      pos;
    pos = -1;
    for (int i = 0; i < held_num; i++) begin
      if (pos < 0 && held_key[i] == b) pos = i;
    end
    if (release_armed) begin
      release_armed = 1'b0;
      if (pos >= 0) begin
        for (int i = pos; i + 1 < held_num; i++) held_key[i] = held_key[i + 1];
        held_num--;
        held_key[held_num] = '0;
      end
    end else if (b == MARK_BYTE) begin
      release_armed = 1'b1;
    end else if (b >= PRESS_LOW && b <= PRESS_HIGH) begin
      if (pos < 0 && held_num < MAX_KEYS_DEF) begin
        held_key[held_num] = b;
        held_num++;
      end
    end
    r = '0;
    for (int j = 0; j < REPORT_SLOTS; j++) begin
      if (j < held_num) r.slot[j] = held_key[j];
    end
    r.count = COUNT_W'(held_num);
    return r;
  endfunction

  // tvalid stays high after the accept; idle() or the next send decides what follows
  task automatic send_item(input logic [BYTE_W-1:0] b, input bit typed, input report_t want);
    report_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = apply_rx_byte(b);
    expected_reports.push_back(typed ? want : pred);
  endtask

  task automatic idle(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle(1);
    while (expected_reports.size() > 0) @(posedge clk);
  endtask

  // receiver: stall pattern switches between a few modes at random intervals
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= stall_mode_t'($urandom_range(3));
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RDY_ALWAYS:   m_axis_tready <= 1'b1;
      RDY_MOSTLY:   m_axis_tready <= ($urandom_range(9) < 7);
      RDY_RARELY:   m_axis_tready <= ($urandom_range(9) < 2);
      RDY_PERIODIC: m_axis_tready <= (cycles[2:0] == 3'd0);
      default:      m_axis_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    report_t got;
    report_t exp_rep;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = report_t'(m_axis_tdata[$bits(report_t)-1:0]);
      if (expected_reports.size() == 0) begin
        $error("report with none expected: %h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        exp_rep = expected_reports.pop_front();
        for (int i = 0; i < REPORT_SLOTS; i++) begin
          if (got.slot[i] !== exp_rep.slot[i]) begin
            $error("slot%0d: expected %h, got %h", i, exp_rep.slot[i], got.slot[i]);
            failed = 1'b1;
          end
        end
        if (got.count !== exp_rep.count) begin
          $error("held_count: expected %0d, got %0d", exp_rep.count, got.count);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    dir_row_t          dir_rows [24];
    logic [BYTE_W-1:0] key_pool [10];
    logic [BYTE_W-1:0] k;
    int unsigned       sent;
    int unsigned       burst_left;
    int unsigned       pick;
    report_t           full_rep;

    for (int i = 0; i < MAX_KEYS_DEF; i++) held_key[i] = '0;
    full_rep = mk_report(6, 8'h04, 8'h65, 8'h10, 8'h20, 8'h30, 8'h40);
    dir_rows = '{
      '{8'hFF, 1'b1, 1'b0, mk_report(0, '0, '0, '0, '0, '0, '0)},      // ignored, empty
      '{8'h04, 1'b1, 1'b0, mk_report(1, 8'h04, '0, '0, '0, '0, '0)},   // lowest press
      '{8'h65, 1'b1, 1'b0, mk_report(2, 8'h04, 8'h65, '0, '0, '0, '0)},  // highest press
      '{8'h03, 1'b1, 1'b0, mk_report(2, 8'h04, 8'h65, '0, '0, '0, '0)},
      '{8'h66, 1'b1, 1'b0, mk_report(2, 8'h04, 8'h65, '0, '0, '0, '0)},
      '{8'h04, 1'b1, 1'b0, mk_report(2, 8'h04, 8'h65, '0, '0, '0, '0)},  // already held
      '{8'h10, 1'b0, 1'b0, '0},
      '{8'h20, 1'b0, 1'b0, '0},
      '{8'h30, 1'b0, 1'b0, '0},
      '{8'h40, 1'b1, 1'b0, full_rep},
      '{8'h50, 1'b1, 1'b0, full_rep},                                 // report full
      '{8'h00, 1'b1, 1'b0, full_rep},
      '{8'h10, 1'b1, 1'b0, mk_report(5, 8'h04, 8'h65, 8'h20, 8'h30, 8'h40, '0)},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},                                       // marker after marker
      '{8'h00, 1'b0, 1'b1, '0},                                       // marker, then pause
      '{8'h04, 1'b0, 1'b0, '0},                                       // release first slot
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h77, 1'b0, 1'b0, '0},                                       // release out of range
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h11, 1'b0, 1'b0, '0},                                       // release not held
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h40, 1'b0, 1'b0, '0},                                       // release last slot
      '{8'h80, 1'b0, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].hold) drain();
    end
    drain();

    foreach (key_pool[i]) key_pool[i] = BYTE_W'($urandom_range(PRESS_LOW, PRESS_HIGH));
    sent = 0;
    burst_left = $urandom_range(1, 16);
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(9)]
                                    : BYTE_W'($urandom_range(PRESS_LOW, PRESS_HIGH));
        send_item(k, 1'b0, '0);
        sent++;
      end else if (pick < 80) begin
        send_item(MARK_BYTE, 1'b0, '0);
        if (held_num > 0 && $urandom_range(9) < 7)
          k = held_key[$urandom_range(held_num - 1)];
        else if ($urandom_range(1))
          k = key_pool[$urandom_range(9)];
        else
          k = BYTE_W'($urandom);
        send_item(k, 1'b0, '0);
        sent += 2;
      end else if (pick < 88) begin
        // lone marker; whatever comes next completes the release
        send_item(MARK_BYTE, 1'b0, '0);
        sent++;
      end else begin
        send_item(BYTE_W'($urandom), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(99) == 0) begin
        key_pool[$urandom_range(9)] = BYTE_W'($urandom_range(PRESS_LOW, PRESS_HIGH));
        drain();
      end
      if (burst_left <= 1) begin
        idle($urandom_range(1, 8));
        burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/kc6_pkg.sv
rtl/kc6_engine.sv
rtl/keycode_stream_to_6key_report_core.sv
tb/sv/keycode_stream_to_6key_report_core_test.sv
